### rtl/core/rba_pkg.sv
// Shared types, field widths and codes for the reference-count block allocator.
`default_nettype none

package rba_pkg;

    localparam int ACT_W = 2;
    localparam int OFF_W = 20;
    localparam int LEN_W = 21;
    localparam int CNT_W = 16;
    localparam int RES_W = 21;
    localparam int ST_W  = 2;

    localparam int DEPTH_BLOCKS_DEF = 4096;
    localparam int BLOCK_BYTES_DEF  = 256;

    localparam logic [ACT_W-1:0] ACT_FIRST_FIT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FREE      = 2'd2;
    localparam logic [ACT_W-1:0] ACT_INCR      = 2'd3;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_BEYOND = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PREP,
        S_SEARCH,
        S_ALLOC,
        S_FILL,
        S_UPDATE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/core/rba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module rba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/refcount_block_allocator.sv
// Top level: block allocator over a table of 16-bit reference counts, by first fit or append,
// with free and increment of the counts of a block range. A reciprocal multiply turns byte
// counts into blocks, a set-up state follows, first fit walks the count RAM one entry per cycle,
// an allocation state checks for room, a fill or update works through the blocks in turn, and
// the result is loaded once the output register is free. Requests are taken one at a time.
// Reset clears the extent and the control state; the count RAM is not cleared.
`default_nettype none

module refcount_block_allocator #(
    parameter int DEPTH_BLOCKS = rba_pkg::DEPTH_BLOCKS_DEF,
    parameter int BLOCK_BYTES  = rba_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [rba_pkg::ACT_W-1:0] i_action,
    input  wire logic [rba_pkg::OFF_W-1:0] i_byte_offset,
    input  wire logic [rba_pkg::LEN_W-1:0] i_length_bytes,
    input  wire logic [rba_pkg::CNT_W-1:0] i_count_value,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic      [rba_pkg::RES_W-1:0] o_result_offset,
    output logic      [rba_pkg::ST_W-1:0]  o_status
);

    import rba_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH_BLOCKS);
    localparam int EXT_W  = $clog2(DEPTH_BLOCKS + 1);
    localparam int BB_W   = $clog2(BLOCK_BYTES + 1);
    localparam int PROD_W = (EXT_W + BB_W > RES_W) ? EXT_W + BB_W : RES_W;
    localparam int SUM_W  = LEN_W + 1;
    localparam int BB_L   = $clog2(BLOCK_BYTES);
    localparam int RCP_W  = SUM_W + 2;
    localparam int RCP_SH = SUM_W + BB_L;
    localparam int MUL_W  = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << RCP_SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));

    t_state             r_state, n_state;
    logic [ACT_W-1:0]   r_action, n_action;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [SUM_W-1:0]   r_len_q, n_len_q;
    logic [LEN_W-1:0]   r_off_q, n_off_q;
    logic [LEN_W-1:0]   r_blocks, n_blocks;
    logic [LEN_W-1:0]   r_issue, n_issue;
    logic [LEN_W-1:0]   r_chk_idx, n_chk_idx;
    logic               r_chk_v, n_chk_v;
    logic [EXT_W-1:0]   r_run, n_run;
    logic               r_found, n_found;
    logic [EXT_W-1:0]   r_pos, n_pos;
    logic [LEN_W-1:0]   r_left, n_left;
    logic [IDX_W-1:0]   r_addr, n_addr;
    logic [EXT_W-1:0]   r_extent, n_extent;
    logic [ST_W-1:0]    r_status, n_status;
    logic               r_out_valid, n_out_valid;
    logic [RES_W-1:0]   r_out_offset, n_out_offset;
    logic [ST_W-1:0]    r_out_status, n_out_status;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [CNT_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [CNT_W-1:0]   ram_rdata;

    logic [MUL_W-1:0]   len_prod, off_prod;
    logic [MUL_W-1:0]   len_quo, off_quo;
    logic [EXT_W-1:0]   run_nxt;
    logic [SUM_W-1:0]   ext_sum;
    logic               grow_full;
    logic               issue_in_ext;
    logic [CNT_W-1:0]   upd_val;
    logic [PROD_W-1:0]  offset_prod;

    rba_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Division by the block size is a multiply by the rounded-up reciprocal, which is exact
    // for every dividend below 2**SUM_W. The length already carries block size minus one,
    // so its quotient is the rounded-up block count.
    assign len_prod = MUL_W'(r_len_q) * MUL_W'(RECIP);
    assign off_prod = MUL_W'(r_off_q) * MUL_W'(RECIP);
    assign len_quo  = len_prod >> RCP_SH;
    assign off_quo  = off_prod >> RCP_SH;

    assign run_nxt      = (ram_rdata == '0) ? r_run + EXT_W'(1) : '0;
    assign ext_sum      = SUM_W'(r_extent) + SUM_W'(r_blocks);
    assign grow_full    = (ext_sum > SUM_W'(DEPTH_BLOCKS));
    assign issue_in_ext = (r_issue < LEN_W'(r_extent));
    assign offset_prod  = PROD_W'(r_pos) * PROD_W'(BLOCK_BYTES);

    always_comb begin
        if (r_action == ACT_FREE) begin
            upd_val = (r_cnt > ram_rdata) ? '0 : ram_rdata - r_cnt;
        end else begin
            upd_val = ram_rdata + r_cnt;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_cnt        = r_cnt;
        n_len_q      = r_len_q;
        n_off_q      = r_off_q;
        n_blocks     = r_blocks;
        n_issue      = r_issue;
        n_chk_idx    = r_chk_idx;
        n_chk_v      = r_chk_v;
        n_run        = r_run;
        n_found      = r_found;
        n_pos        = r_pos;
        n_left       = r_left;
        n_addr       = r_addr;
        n_extent     = r_extent;
        n_status     = r_status;
        n_out_valid  = r_out_valid & i_out_stall;
        n_out_offset = r_out_offset;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_addr;
        ram_wdata    = r_cnt;
        ram_re       = 1'b0;
        ram_raddr    = r_issue[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action  = i_action;
                    n_cnt     = i_count_value;
                    n_len_q   = SUM_W'(i_length_bytes) + SUM_W'(BLOCK_BYTES - 1);
                    n_off_q   = LEN_W'(i_byte_offset);
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                n_blocks = len_quo[LEN_W-1:0];
                n_off_q  = off_quo[LEN_W-1:0];
                n_state  = S_PREP;
            end
            S_PREP: begin
                n_chk_v  = 1'b0;
                n_found  = 1'b0;
                unique case (r_action)
                    ACT_FIRST_FIT: begin
                        n_issue = '0;
                        n_run   = '0;
                        n_state = S_SEARCH;
                    end
                    ACT_APPEND: begin
                        n_pos   = r_extent;
                        n_state = S_ALLOC;
                    end
                    ACT_FREE, ACT_INCR: begin
                        n_issue  = r_off_q;
                        n_left   = r_blocks;
                        n_pos    = '0;
                        n_status = ST_OK;
                        n_state  = S_UPDATE;
                    end
                endcase
            end
            S_SEARCH: begin
                // Reads stream one entry a cycle; the run check works on the registered read data, marked by r_chk_v.
                n_chk_v = 1'b0;
                if (r_chk_v && (LEN_W'(run_nxt) == r_blocks)) begin
                    n_found = 1'b1;
                    n_pos   = EXT_W'(r_chk_idx + LEN_W'(1) - r_blocks);
                    n_state = S_ALLOC;
                end else begin
                    if (r_chk_v) begin
                        n_run = run_nxt;
                    end
                    if (issue_in_ext) begin
                        ram_re    = 1'b1;
                        n_issue   = r_issue + LEN_W'(1);
                        n_chk_idx = r_issue;
                        n_chk_v   = 1'b1;
                    end else if (!r_chk_v) begin
                        n_pos   = r_extent;
                        n_state = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                if (!r_found && grow_full) begin
                    n_pos    = '0;
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_status = ST_OK;
                    n_left   = r_blocks;
                    n_addr   = r_pos[IDX_W-1:0];
                    if (!r_found) begin
                        n_extent = r_extent + EXT_W'(r_blocks);
                    end
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (r_left != '0) begin
                    ram_we = 1'b1;
                    n_addr = r_addr + IDX_W'(1);
                    n_left = r_left - LEN_W'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UPDATE: begin
                // Consecutive blocks differ in address, so the write-back of one block
                // never meets the read of the next.
                if (r_chk_v) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_chk_idx[IDX_W-1:0];
                    ram_wdata = upd_val;
                end
                n_chk_v = 1'b0;
                if (r_left != '0) begin
                    if (issue_in_ext) begin
                        ram_re    = 1'b1;
                        n_issue   = r_issue + LEN_W'(1);
                        n_left    = r_left - LEN_W'(1);
                        n_chk_idx = r_issue;
                        n_chk_v   = 1'b1;
                    end else begin
                        n_status = ST_BEYOND;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_offset = offset_prod[RES_W-1:0];
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk_v     <= 1'b0;
            r_extent    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk_v     <= n_chk_v;
            r_extent    <= n_extent;
            r_out_valid <= n_out_valid;
        end
        r_action     <= n_action;
        r_cnt        <= n_cnt;
        r_len_q      <= n_len_q;
        r_off_q      <= n_off_q;
        r_blocks     <= n_blocks;
        r_issue      <= n_issue;
        r_chk_idx    <= n_chk_idx;
        r_run        <= n_run;
        r_found      <= n_found;
        r_pos        <= n_pos;
        r_left       <= n_left;
        r_addr       <= n_addr;
        r_status     <= n_status;
        r_out_offset <= n_out_offset;
        r_out_status <= n_out_status;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_result_offset = r_out_offset;
    assign o_status        = r_out_status;

    a_extent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_extent <= EXT_W'(DEPTH_BLOCKS))
        else $error("extent exceeds table depth");

    a_write_in_extent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (EXT_W'(ram_waddr) < r_extent))
        else $error("count write outside the extent");

    a_read_in_extent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (EXT_W'(ram_raddr) < r_extent))
        else $error("count read outside the extent");

    a_extent_only_on_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_extent) |-> ($past(r_state) == S_ALLOC))
        else $error("extent changed outside allocation");

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DIV))
        else $error("accepted transfer did not start division");

    a_full_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> (o_result_offset == '0))
        else $error("full status with nonzero offset");

endmodule

`default_nettype wire

### dv/tb.sv
// Testbench for the reference-count block allocator: directed and random requests checked.
`timescale 1ns / 1ps

module tb;
    import rba_pkg::*;

    localparam int DEPTH       = DEPTH_BLOCKS_DEF;
    localparam int BLOCK_BYTES = BLOCK_BYTES_DEF;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(DEPTH * BLOCK_BYTES);
    // Keeps the random part's extent short so that first-fit walks stay cheap.
    localparam int RANDOM_EXTENT_CAP = 256;

    typedef struct packed {
        logic [RES_W-1:0] offset;
        logic [ST_W-1:0]  status;
    } t_alloc_result;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    logic [ACT_W-1:0] req_action = ACT_FIRST_FIT;
    logic [OFF_W-1:0] req_byte_offset = '0;
    logic [LEN_W-1:0] req_length = '0;
    logic [CNT_W-1:0] req_count = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    logic [RES_W-1:0] rsp_offset;
    logic [ST_W-1:0]  rsp_status;

    // Shadow copy of the allocator state.
    logic [CNT_W-1:0] shadow_counts [DEPTH];
    int               shadow_extent = 0;
    t_alloc_result    pending_results[$];
    t_alloc_result    oldest_expected;

    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    refcount_block_allocator i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .o_in_stall     (req_stall),
        .i_action       (req_action),
        .i_byte_offset  (req_byte_offset),
        .i_length_bytes (req_length),
        .i_count_value  (req_count),
        .o_out_valid    (rsp_valid),
        .i_out_stall    (rsp_stall),
        .o_result_offset(rsp_offset),
        .o_status       (rsp_status)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int blocks_of(input logic [LEN_W-1:0] len);
        return (int'(len) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    endfunction

    // Start of the first run of nblocks zero counts inside the extent, or -1.
    function automatic int find_free_run(input int nblocks);
        int run;
        run = 0;
        for (int i = 0; i < shadow_extent; i++) begin
            run = (shadow_counts[i] == '0) ? run + 1 : 0;
            if (run == nblocks) return i + 1 - nblocks;
        end
        return -1;
    endfunction

    function automatic t_alloc_result predict_request(input logic [ACT_W-1:0] act,
                                                      input logic [OFF_W-1:0] off,
                                                      input logic [LEN_W-1:0] len,
                                                      input logic [CNT_W-1:0] cnt);
        t_alloc_result r;
        int nblocks;
        int pos;
        int first;
        r = '0;
        nblocks = blocks_of(len);
        if (act == ACT_FIRST_FIT || act == ACT_APPEND) begin
            pos = (act == ACT_FIRST_FIT) ? find_free_run(nblocks) : -1;
            if (pos < 0 && shadow_extent + nblocks > DEPTH) begin
                r.status = ST_FULL;
            end else begin
                if (pos < 0) begin
                    pos = shadow_extent;
                    shadow_extent += nblocks;
                end
                for (int k = 0; k < nblocks; k++) shadow_counts[pos + k] = cnt;
                r.offset = RES_W'(pos * BLOCK_BYTES);
            end
        end else begin
            first = int'(off) / BLOCK_BYTES;
            for (int k = 0; k < nblocks; k++) begin
                if (first + k >= shadow_extent) begin
                    r.status = ST_BEYOND;
                    break;
                end
                if (act == ACT_FREE) begin
                    shadow_counts[first + k] = (cnt > shadow_counts[first + k]) ?
                                               '0 : shadow_counts[first + k] - cnt;
                end else begin
                    shadow_counts[first + k] = shadow_counts[first + k] + cnt;
                end
            end
        end
        return r;
    endfunction

    // Drives one request and waits for its transfer; returns at the accepting edge.
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [OFF_W-1:0] off,
                                input logic [LEN_W-1:0] len, input logic [CNT_W-1:0] cnt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid       <= 1'b1;
        req_action      <= act;
        req_byte_offset <= off;
        req_length      <= len;
        req_count       <= cnt;
        do @(posedge clk); while (req_stall !== 1'b0);
        pending_results.push_back(predict_request(act, off, len, cnt));
    endtask

    task automatic wait_until_drained();
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_empty_table();
        send_request(ACT_FIRST_FIT, '0, '0, '0);
        send_request(ACT_APPEND, '1, '0, '1);
        send_request(ACT_FREE, '0, 21'd1, 16'd1);
        send_request(ACT_INCR, '0, '0, '1);
    endtask

    task automatic test_alloc_and_counts();
        send_request(ACT_APPEND, '0, 21'd700, 16'd5);
        // No zero entry yet, so this one goes to the extent and writes a zero count.
        send_request(ACT_FIRST_FIT, '0, 21'd1, 16'd0);
        send_request(ACT_FIRST_FIT, '0, 21'd256, 16'd7);
        send_request(ACT_FREE, '0, 21'd512, '1);
        send_request(ACT_INCR, 20'd256, 21'd1, '1);
        send_request(ACT_INCR, 20'd300, 21'd2, 16'd1);
        send_request(ACT_FREE, 20'd768, 21'd768, 16'd3);
        send_request(ACT_APPEND, '0, 21'd512, 16'd9);
        send_request(ACT_FREE, 20'd1280, 21'd1, 16'd9);
        // Neither the two zero blocks at the start nor the single one at the end of the extent fits three blocks.
        send_request(ACT_FIRST_FIT, '0, 21'd600, 16'd12);
        send_request(ACT_FIRST_FIT, '0, '0, '0);
        send_request(ACT_FIRST_FIT, '0, 21'd512, 16'd1);
    endtask

    task automatic test_edge_fields();
        send_request(ACT_APPEND, '0, MAX_LEN, '0);
        send_request(ACT_FIRST_FIT, '1, MAX_LEN, '1);
        send_request(ACT_FREE, '1, MAX_LEN, '1);
        send_request(ACT_INCR, '0, MAX_LEN, 16'd1);
        send_request(ACT_FREE, '0, MAX_LEN, '1);
        send_request(ACT_FIRST_FIT, '0, '0, '0);
        send_request(ACT_FIRST_FIT, '0, 21'd1, 16'd3);
        send_request(ACT_APPEND, 20'h5A5A5, 21'd255, 16'd2);
    endtask

    task automatic test_random(input int n_items);
        logic [ACT_W-1:0] act;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
        int pick;
        int nblocks;
        for (int n = 0; n < n_items; n++) begin
            act = ACT_W'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 5) len = LEN_W'($urandom_range(0, int'(MAX_LEN)));
            else if (pick < 10) len = '0;
            else len = LEN_W'($urandom_range(1, 8 * BLOCK_BYTES));
            pick = $urandom_range(0, 9);
            cnt = (pick == 0) ? '0 : (pick == 1) ? '1 : CNT_W'($urandom);
            if ((act == ACT_FREE || act == ACT_INCR) && $urandom_range(0, 3) != 0)
                off = OFF_W'($urandom_range(0, shadow_extent * BLOCK_BYTES + 511));
            else
                off = OFF_W'($urandom);
            nblocks = blocks_of(len);
            // An allocation that would grow the extent past the cap but stay within the table
            // becomes a free instead, which opens holes for later first-fit requests.
            if ((act == ACT_APPEND || (act == ACT_FIRST_FIT && find_free_run(nblocks) < 0))
                && shadow_extent + nblocks > RANDOM_EXTENT_CAP
                && shadow_extent + nblocks <= DEPTH) begin
                act = ACT_FREE;
                off = OFF_W'($urandom_range(0, shadow_extent * BLOCK_BYTES));
                len = LEN_W'($urandom_range(1, 32 * BLOCK_BYTES));
                cnt = '1;
            end
            send_request(act, off, len, cnt);
        end
    endtask

    task automatic test_full_table();
        send_request(ACT_APPEND, '0, LEN_W'((DEPTH - shadow_extent) * BLOCK_BYTES), 16'd1);
        send_request(ACT_APPEND, '0, 21'd1, 16'd1);
        send_request(ACT_FIRST_FIT, '0, 21'd257, 16'd2);
        send_request(ACT_FREE, '0, MAX_LEN, '1);
        send_request(ACT_FIRST_FIT, '0, MAX_LEN, 16'd4);
        send_request(ACT_INCR, '1, MAX_LEN, '1);
        send_request(ACT_FIRST_FIT, '0, '0, '0);
    endtask

    always @(posedge clk) begin
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual offset %0h status %0d",
                         $time, rsp_offset, rsp_status);
                mismatches++;
            end else begin
                oldest_expected = pending_results.pop_front();
                if (rsp_offset !== oldest_expected.offset) begin
                    $display("%0t: offset mismatch, expected %0h actual %0h",
                             $time, oldest_expected.offset, rsp_offset);
                    mismatches++;
                end
                if (rsp_status !== oldest_expected.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, oldest_expected.status, rsp_status);
                    mismatches++;
                end
            end
        end
        rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    initial begin
        send_idle_pct = 7;
        recv_idle_pct = 72;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_alloc_and_counts();
        test_edge_fields();
        test_random(500);
        wait_until_drained();
        send_idle_pct = 72;
        recv_idle_pct = 7;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);
        test_full_table();
        req_valid <= 1'b0;
        for (int w = 0; w < 50000 && pending_results.size() != 0; w++) @(posedge clk);
        repeat (100) @(posedge clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived, expected offset %0h status %0d",
                     $time, pending_results.size(), pending_results[0].offset,
                     pending_results[0].status);
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("PASS refcount_block_allocator");
        end else begin
            $display("FAIL refcount_block_allocator");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("FAIL refcount_block_allocator");
        $finish;
    end

endmodule
